FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clock outside reset.
`define CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising edge of clock outside reset.
`define CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ctt_pkg.sv
package ctt_pkg;

   // Command codes
   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_ADD_ONE = 3'd1;
   localparam logic [2:0] CMD_ADD_PER = 3'd2;
   localparam logic [2:0] CMD_RM_SLOT = 3'd3;
   localparam logic [2:0] CMD_RM_ALL  = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_FREE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EXPIRED  = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctt_ctl_type;

   // Datapath to controller status
   typedef struct packed {
      logic last;
   } ctt_sts_type;

endpackage

FILE: design/ctt_ctrl.sv
module ctt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ctt_pkg::ctt_sts_type sts,
   output ctt_pkg::ctt_ctl_type ctl,
   output logic                 busy,
   output logic                 rsp_valid
);
   import ctt_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Sequence one word: load, sweep, drain the read stage, respond
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            ctl.step = 1'b1;
            if (sts.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            ctl.finish = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

FILE: design/ctt_dpath.sv
module ctt_dpath #(
   parameter int SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           req_cmd,
   input  logic [2:0]           req_slot,
   input  logic                 req_any_slot,
   input  logic [31:0]          req_delay,
   input  ctt_pkg::ctt_ctl_type ctl,
   output ctt_pkg::ctt_sts_type sts,
   output logic [1:0]           rsp_status,
   output logic [2:0]           rsp_assigned_slot,
   output logic [7:0]           rsp_fired_mask
);
   import ctt_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int XW = (AW > 3) ? AW : 3;

   // Latched request word
   logic [2:0]  cmd_ff;
   logic [2:0]  slot_ff;
   logic        any_ff;
   logic [31:0] delay_ff;

   // Slot state: flags in flops, countdown and period in memory
   logic [SLOTS-1:0] active_ff, active_in;
   logic [SLOTS-1:0] written_ff, written_in;
   logic [31:0]      rem_mem [SLOTS];
   logic [31:0]      per_mem [SLOTS];
   logic [31:0]      rem_rd_ff;
   logic [31:0]      per_rd_ff;
   logic             rd_written_ff;

   // Sweep and read stage
   logic [AW-1:0] idx_ff, idx_in;
   logic          proc_valid_ff, proc_valid_in;
   logic [AW-1:0] proc_idx_ff, proc_idx_in;

   // Result accumulators
   logic       found_ff, found_in;
   logic       not_free_ff, not_free_in;
   logic       zero_seen_ff, zero_seen_in;
   logic [2:0] assigned_ff, assigned_in;
   logic [7:0] fired_ff, fired_in;

   // Memory write port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_rem;
   logic [31:0]   wr_per;

   logic [XW-1:0] slot_x;
   logic [XW-1:0] idx_x;
   logic [XW-1:0] proc_idx_x;
   logic          slot_ok;
   logic [AW-1:0] slot_addr;
   logic [AW-1:0] rd_addr;
   logic          last_idx;
   logic          is_tick, is_add, is_rm_slot, is_rm_all;
   logic [31:0]   period_val;
   logic [31:0]   eff_rem;
   logic [31:0]   dec_rem;

   // Decode the held word
   assign slot_x     = XW'(slot_ff);
   assign idx_x      = XW'(idx_ff);
   assign proc_idx_x = XW'(proc_idx_ff);
   assign slot_ok    = ({1'b0, slot_x} < (XW+1)'(SLOTS));
   assign slot_addr  = slot_x[AW-1:0];
   assign last_idx   = (idx_ff == AW'(SLOTS - 1));
   assign is_tick    = (cmd_ff == CMD_TICK);
   assign is_add     = (cmd_ff == CMD_ADD_ONE) || (cmd_ff == CMD_ADD_PER);
   assign is_rm_slot = (cmd_ff == CMD_RM_SLOT);
   assign is_rm_all  = (cmd_ff == CMD_RM_ALL);
   assign period_val = (cmd_ff == CMD_ADD_PER) ? delay_ff : 32'd0;
   assign rd_addr    = is_rm_slot ? slot_addr : idx_ff;

   // Never-written countdowns read as zero
   assign eff_rem = rd_written_ff ? rem_rd_ff : 32'd0;
   assign dec_rem = eff_rem - 32'd1;

   // Sweep commands end on the last slot, the others after one step
   assign sts.last = (is_tick || is_rm_all || (is_add && any_ff)) ? last_idx : 1'b1;

   always_comb begin
      idx_in        = idx_ff;
      proc_valid_in = 1'b0;
      proc_idx_in   = rd_addr;
      active_in     = active_ff;
      written_in    = written_ff;
      found_in      = found_ff;
      not_free_in   = not_free_ff;
      zero_seen_in  = zero_seen_ff;
      assigned_in   = assigned_ff;
      fired_in      = fired_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_rem        = delay_ff;
      wr_per        = period_val;

      // Clear accumulators for a new word
      if (ctl.load) begin
         idx_in       = '0;
         found_in     = 1'b0;
         not_free_in  = 1'b0;
         zero_seen_in = 1'b0;
         assigned_in  = 3'd0;
         fired_in     = 8'd0;
      end

      // Read stage: count down a slot, or check a removed countdown
      if (proc_valid_ff) begin
         if (is_tick) begin
            wr_en   = 1'b1;
            wr_addr = proc_idx_ff;
            wr_per  = per_rd_ff;
            wr_rem  = dec_rem;
            if (dec_rem == 32'd0) begin
               if ((XW+1)'(proc_idx_x) < (XW+1)'(8)) begin
                  fired_in[proc_idx_x[2:0]] = 1'b1;
               end
               if (per_rd_ff != 32'd0) begin
                  wr_rem = per_rd_ff;
               end else begin
                  active_in[proc_idx_ff] = 1'b0;
               end
            end
         end else if (eff_rem == 32'd0) begin
            zero_seen_in = 1'b1;
         end
      end

      // Step: advance the sweep and act on the current slot
      if (ctl.step) begin
         if (!last_idx) begin
            idx_in = idx_ff + AW'(1);
         end
         case (cmd_ff) inside
            CMD_TICK: begin
               proc_valid_in = active_ff[idx_ff];
            end
            CMD_ADD_ONE, CMD_ADD_PER: begin
               if (any_ff) begin
                  if (!found_ff && !active_ff[idx_ff]) begin
                     wr_en               = 1'b1;
                     wr_addr             = idx_ff;
                     active_in[idx_ff]   = 1'b1;
                     written_in[idx_ff]  = 1'b1;
                     found_in            = 1'b1;
                     assigned_in         = idx_x[2:0];
                  end
               end else if (slot_ok && !active_ff[slot_addr]) begin
                  wr_en                 = 1'b1;
                  wr_addr               = slot_addr;
                  active_in[slot_addr]  = 1'b1;
                  written_in[slot_addr] = 1'b1;
                  assigned_in           = slot_ff;
               end else begin
                  not_free_in = 1'b1;
               end
            end
            CMD_RM_SLOT: begin
               proc_valid_in = slot_ok;
            end
            CMD_RM_ALL: begin
               proc_valid_in = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Finish: drop the removed slots
      if (ctl.finish) begin
         if (is_rm_slot && slot_ok) begin
            active_in[slot_addr] = 1'b0;
         end
         if (is_rm_all) begin
            active_in = '0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         written_ff    <= '0;
         proc_valid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         written_ff    <= written_in;
         proc_valid_ff <= proc_valid_in;
      end
   end

   // Payload and accumulators
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_cmd;
         slot_ff  <= req_slot;
         any_ff   <= req_any_slot;
         delay_ff <= req_delay;
      end
      idx_ff       <= idx_in;
      proc_idx_ff  <= proc_idx_in;
      found_ff     <= found_in;
      not_free_ff  <= not_free_in;
      zero_seen_ff <= zero_seen_in;
      assigned_ff  <= assigned_in;
      fired_ff     <= fired_in;
   end

   // Countdown and period memories, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rem_mem[wr_addr] <= wr_rem;
         per_mem[wr_addr] <= wr_per;
      end
      rem_rd_ff     <= rem_mem[rd_addr];
      per_rd_ff     <= per_mem[rd_addr];
      rd_written_ff <= written_ff[rd_addr];
   end

   // Form the response word
   always_comb begin
      if (is_add && any_ff && !found_ff) begin
         rsp_status = ST_FULL;
      end else if (not_free_ff) begin
         rsp_status = ST_NOT_FREE;
      end else if (zero_seen_ff) begin
         rsp_status = ST_EXPIRED;
      end else begin
         rsp_status = ST_OK;
      end
   end

   assign rsp_assigned_slot = assigned_ff;
   assign rsp_fired_mask    = fired_ff;

endmodule

FILE: design/countdown_task_slot_table.sv
// Channel    | Handshake              | Word fields
// -----------+------------------------+-------------------------------------------
// request    | start while busy low   | req_cmd, req_slot, req_any_slot, req_delay
// response   | rsp_valid, one cycle   | rsp_status, rsp_assigned_slot, rsp_fired_mask
//
// Tick, remove-all and add to any slot sweep every slot in turn; named add,
// remove of one slot and unknown commands end after the first sweep step.
// The sweep visits one slot a cycle through the single read port of the
// countdown and period memories, and a read-stage drain follows it.
// Synchronous reset clears all active flags and written marks at once; no
// clearing pass. The receiver cannot stall: busy stays high until the
// response cycle has passed, then the next word is taken.
`include "assert_macros.svh"

module countdown_task_slot_table #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [2:0]  req_slot,
   input  logic        req_any_slot,
   input  logic [31:0] req_delay,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_assigned_slot,
   output logic [7:0]  rsp_fired_mask
);
   import ctt_pkg::*;

   ctt_ctl_type ctl;
   ctt_sts_type sts;

   ctt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ctt_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_any_slot      (req_any_slot),
      .req_delay         (req_delay),
      .ctl               (ctl),
      .sts               (sts),
      .rsp_status        (rsp_status),
      .rsp_assigned_slot (rsp_assigned_slot),
      .rsp_fired_mask    (rsp_fired_mask)
   );

   // Accepted word makes the block busy next cycle
   `CHECK_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   // Response only while a word is held
   `CHECK_NOW(a_resp_busy, rsp_valid, busy, "response outside a held word")
   // Exactly one response cycle, then idle
   `CHECK_NEXT(a_resp_single, rsp_valid, !rsp_valid, "response held for two cycles")
   `CHECK_NEXT(a_resp_idle, rsp_valid, !busy, "block still busy after response")

endmodule

FILE: bench/countdown_task_slot_table_tb.sv
`timescale 1ns / 100ps

module countdown_task_slot_table_tb;
   import ctt_pkg::*;

   localparam int SLOTS = 8;
   // highest encoding of the command field; codes above CMD_RM_ALL do nothing
   localparam logic [2:0] CMD_TOP = 3'd7;
   localparam logic [31:0] DELAY_MAX = 32'hFFFF_FFFF;
   localparam int RANDOM_WORDS = 1700;
   localparam int DRAIN_EVERY = 300;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_cmd;
   logic [2:0]  req_slot;
   logic        req_any_slot;
   logic [31:0] req_delay;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_assigned_slot;
   logic [7:0]  rsp_fired_mask;

   countdown_task_slot_table #(.SLOTS(SLOTS)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_any_slot      (req_any_slot),
      .req_delay         (req_delay),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_assigned_slot (rsp_assigned_slot),
      .rsp_fired_mask    (rsp_fired_mask)
   );

   // Mirror of the timer table plus the replies still owed by the block
   class timer_table_scoreboard;
      typedef struct {
         logic [1:0] status;
         logic [2:0] assigned_slot;
         logic [7:0] fired_mask;
      } reply_type;

      bit          armed     [SLOTS];
      logic [31:0] countdown [SLOTS];
      logic [31:0] reload    [SLOTS];
      reply_type   replies_owed [$];
      int          mismatches;
      int          replies_seen;
      int          fire_replies;
      int          full_replies;
      int          taken_replies;
      int          expired_replies;

      function new();
         int i;
         for (i = 0; i < SLOTS; i++) begin
            armed[i] = 1'b0;
            countdown[i] = '0;
            reload[i] = '0;
         end
         mismatches = 0;
         replies_seen = 0;
         fire_replies = 0;
         full_replies = 0;
         taken_replies = 0;
         expired_replies = 0;
      endfunction

      function void arm_slot(int i, logic [31:0] delay, logic [31:0] period);
         armed[i] = 1'b1;
         countdown[i] = delay;
         reload[i] = period;
      endfunction

      // Advance the table by one accepted word and queue the reply it owes
      function void note_word(logic [2:0] cmd, logic [2:0] slot, logic any_slot,
                              logic [31:0] delay);
         reply_type   r;
         logic [31:0] period;
         int          i;
         r.status = ST_OK;
         r.assigned_slot = '0;
         r.fired_mask = '0;
         period = (cmd == CMD_ADD_PER) ? delay : 32'd0;
         case (cmd)
            CMD_TICK: begin
               // count down armed slots only; fire, then reload or disarm
               for (i = 0; i < SLOTS; i++) begin
                  if (armed[i]) begin
                     countdown[i] = countdown[i] - 32'd1;
                     if (countdown[i] == 32'd0) begin
                        if (i < 8) r.fired_mask[i] = 1'b1;
                        if (reload[i] != 32'd0) countdown[i] = reload[i];
                        else armed[i] = 1'b0;
                     end
                  end
               end
            end
            CMD_ADD_ONE, CMD_ADD_PER: begin
               if (any_slot) begin
                  // take the lowest free slot, or report a full table
                  r.status = ST_FULL;
                  for (i = 0; i < SLOTS && r.status == ST_FULL; i++) begin
                     if (!armed[i]) begin
                        arm_slot(i, delay, period);
                        r.status = ST_OK;
                        r.assigned_slot = 3'(i);
                     end
                  end
               end else if (int'(slot) < SLOTS && !armed[slot]) begin
                  arm_slot(int'(slot), delay, period);
                  r.assigned_slot = slot;
               end else begin
                  r.status = ST_NOT_FREE;
               end
            end
            CMD_RM_SLOT: begin
               if (int'(slot) < SLOTS) begin
                  if (countdown[slot] == 32'd0) r.status = ST_EXPIRED;
                  armed[slot] = 1'b0;
               end
            end
            CMD_RM_ALL: begin
               for (i = 0; i < SLOTS; i++) begin
                  if (countdown[i] == 32'd0) r.status = ST_EXPIRED;
                  armed[i] = 1'b0;
               end
            end
            default: begin
            end
         endcase
         if (r.fired_mask != '0) fire_replies++;
         if (r.status == ST_FULL) full_replies++;
         if (r.status == ST_NOT_FREE) taken_replies++;
         if (r.status == ST_EXPIRED) expired_replies++;
         replies_owed.push_back(r);
      endfunction

      // Compare one reply with the oldest owed one
      function void check_result(logic [1:0] status, logic [2:0] assigned_slot,
                                 logic [7:0] fired_mask);
         reply_type want;
         if (replies_owed.size() == 0) begin
            $error("reply with no word outstanding: status %0d slot %0d mask %0h",
                   status, assigned_slot, fired_mask);
            mismatches++;
            return;
         end
         want = replies_owed.pop_front();
         replies_seen++;
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (assigned_slot !== want.assigned_slot) begin
            $error("assigned_slot: expected %0d, actual %0d",
                   want.assigned_slot, assigned_slot);
            mismatches++;
         end
         if (fired_mask !== want.fired_mask) begin
            $error("fired_mask: expected %02h, actual %02h", want.fired_mask, fired_mask);
            mismatches++;
         end
      endfunction
   endclass

   timer_table_scoreboard sb;
   bit no_idle;

   // Free-running clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watchdog
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Check every reply word on the cycle it is shown
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_status, rsp_assigned_slot, rsp_fired_mask);
      end
   end

   // Present one word after a random gap and hold it until accepted
   task automatic send_word(logic [2:0] cmd, logic [2:0] slot, logic any_slot,
                            logic [31:0] delay);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_slot <= slot;
      req_any_slot <= any_slot;
      req_delay <= delay;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(cmd, slot, any_slot, delay);
   endtask

   // Hold off until every owed reply has come back
   task automatic drain_replies();
      start <= 1'b0;
      do @(posedge clock); while (sb.replies_owed.size() != 0);
   endtask

   // Draw one word: mostly ticks and short timers so slots fire and reload often
   task automatic random_word(output bit ignored);
      int          pick;
      int          dsel;
      logic [2:0]  cmd;
      logic [31:0] delay;
      pick = $urandom_range(0, 99);
      if (pick < 42) cmd = CMD_TICK;
      else if (pick < 58) cmd = CMD_ADD_ONE;
      else if (pick < 74) cmd = CMD_ADD_PER;
      else if (pick < 88) cmd = CMD_RM_SLOT;
      else if (pick < 93) cmd = CMD_RM_ALL;
      else cmd = 3'($urandom_range(int'(CMD_RM_ALL) + 1, int'(CMD_TOP)));
      dsel = $urandom_range(0, 99);
      if (dsel < 8) delay = '0;
      else if (dsel < 80) delay = 32'($urandom_range(1, 6));
      else delay = $urandom();
      ignored = (cmd > CMD_RM_ALL);
      send_word(cmd, 3'($urandom_range(0, SLOTS - 1)), 1'($urandom_range(0, 1)), delay);
   endtask

   initial begin
      int  sent;
      int  i;
      bit  ignored;
      sb = new();
      no_idle = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_TICK;
      req_slot = '0;
      req_any_slot = 1'b0;
      req_delay = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, unknown codes, named and free-slot adds, fill, removes
      send_word(CMD_TICK, 3'd0, 1'b0, 32'd0);
      send_word(CMD_RM_SLOT, 3'd7, 1'b1, DELAY_MAX);
      send_word(CMD_RM_ALL, 3'd0, 1'b0, 32'd0);
      send_word(CMD_RM_ALL + 3'd1, 3'd7, 1'b1, DELAY_MAX);
      send_word(CMD_RM_ALL + 3'd2, 3'd0, 1'b0, 32'd0);
      send_word(CMD_TOP, 3'd5, 1'b1, 32'h5A5A_A5A5);
      send_word(CMD_ADD_ONE, 3'd0, 1'b0, 32'd1);
      send_word(CMD_ADD_PER, 3'd7, 1'b0, 32'd2);
      send_word(CMD_ADD_ONE, 3'd0, 1'b0, 32'd9);
      send_word(CMD_TICK, 3'd7, 1'b1, DELAY_MAX);
      send_word(CMD_TICK, 3'd0, 1'b0, 32'd0);
      send_word(CMD_ADD_ONE, 3'd4, 1'b1, 32'd0);
      send_word(CMD_ADD_PER, 3'd4, 1'b1, 32'd0);
      send_word(CMD_ADD_ONE, 3'd0, 1'b1, DELAY_MAX);
      for (i = 0; i < 5; i++) send_word(CMD_ADD_PER, 3'd0, 1'b1, 32'd3);
      send_word(CMD_ADD_PER, 3'd2, 1'b0, 32'd3);
      send_word(CMD_RM_SLOT, 3'd0, 1'b0, 32'd0);
      send_word(CMD_RM_SLOT, 3'd2, 1'b1, 32'd0);
      send_word(CMD_TICK, 3'd0, 1'b0, 32'd0);
      send_word(CMD_RM_ALL, 3'd0, 1'b1, 32'd0);
      send_word(CMD_ADD_PER, 3'd0, 1'b1, 32'd1);
      send_word(CMD_TICK, 3'd0, 1'b0, 32'd0);
      drain_replies();

      // Random: bursts without gaps come at random among idle-heavy stretches
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         if (sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         random_word(ignored);
         if (!ignored) begin
            sent++;
            if (sent % DRAIN_EVERY == 0) drain_replies();
         end
      end
      start <= 1'b0;

      // Wind down: wait for owed replies, then a quiet window for strays
      while (sb.replies_owed.size() != 0) @(posedge clock);
      repeat (2 * (SLOTS + 3)) @(posedge clock);
      $display("Run covered %0d replies: %0d ticks with fired slots, %0d full-table adds,",
               sb.replies_seen, sb.fire_replies, sb.full_replies);
      $display("%0d adds to a taken slot and %0d removes of expired timers.",
               sb.taken_replies, sb.expired_replies);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
